// File: design/pstc_pkg.sv
`default_nettype none

package pstc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_MIN_RANGE   = 2'd2,
        CFG_MAX_RANGE   = 2'd3
    } t_cfg_idx;

    // Field widths.
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned RANGE_W = 16;
    localparam int unsigned COORD_W = 17;
    localparam int unsigned CFG_W   = 32;

    // Fixed-point constants used to build the sine table (Q30).
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_FRAC    = 64'h3FFF_FFFF;

    // One quarter turn in binary angle units.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

endpackage

`default_nettype wire

// File: design/polar_scan_to_cartesian_top.sv
`default_nettype none

// Converts a stream of planar lidar range samples (unsigned millimetres) into
// x/y points. The angle register is loaded from start_angle on a sample that
// carries the scan-start flag and otherwise advances by angle_step, wrapping
// modulo one turn. Cosine and sine come from a constant table of
// SINE_TABLE_DEPTH entries in signed fixed point with SINE_FRACTION_BITS
// fraction bits; each coordinate is r times the table value, rounded half up
// to whole millimetres. A sample flagged special or outside the inclusive
// window [min_range, max_range] yields x = y = 0 with the valid flag clear.
// The block takes one sample per clock unless the output stalls, and passes
// each one from input transaction to output through an input stage holding
// the new angle and range check, a stage that reads both table entries into
// registers, and the output register holding the two products. A stalled
// output backs up stage by stage, so empty stages still take new samples.
// Configuration writes are expected only while no sample is in flight.
module polar_scan_to_cartesian_top #(
    parameter int unsigned SINE_TABLE_DEPTH   = 1024,
    parameter int unsigned SINE_FRACTION_BITS = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Sample input.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,    // [15:0] range_mm
    input  wire logic [1:0]  i_s_tuser,    // [0] range_special, [1] scan_start
    // Point output.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,    // [16:0] x_mm, [33:17] y_mm, [39:34] zero
    output logic             o_m_tuser,    // [0] point_valid
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire pstc_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [pstc_pkg::CFG_W-1:0] i_cfg_wdata
);

    import pstc_pkg::*;

    localparam int unsigned IDX_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int unsigned SIN_W  = SINE_FRACTION_BITS + 2;
    localparam int unsigned PROD_W = RANGE_W + 1 + SIN_W;
    localparam int unsigned KMUL_W = ANGLE_W + IDX_W;

    // ------------------------------------------------------------------
    // Sine table, built at elaboration.
    // ------------------------------------------------------------------
    logic signed [SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] KK   = 64'(k);
        localparam logic [63:0] BANG = ((KK << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
        localparam logic [1:0]  QUAD = BANG[31:30];
        localparam logic [63:0] F0   = BANG & Q30_FRAC;
        localparam logic [63:0] F1   = QUAD[0] ? (Q30_ONE - F0) : F0;
        localparam logic [63:0] TH   = (F1 * HALF_PI_Q30) >> 30;
        localparam logic [63:0] TH2  = (TH * TH) >> 30;
        // Horner evaluation of the odd Taylor series through theta^13.
        localparam logic [63:0] T1   = Q30_ONE - (((TH2 * Q30_ONE) >> 30) / 156);
        localparam logic [63:0] T2   = Q30_ONE - (((TH2 * T1) >> 30) / 110);
        localparam logic [63:0] T3   = Q30_ONE - (((TH2 * T2) >> 30) / 72);
        localparam logic [63:0] T4   = Q30_ONE - (((TH2 * T3) >> 30) / 42);
        localparam logic [63:0] T5   = Q30_ONE - (((TH2 * T4) >> 30) / 20);
        localparam logic [63:0] T6   = Q30_ONE - (((TH2 * T5) >> 30) / 6);
        localparam logic [63:0] S0   = (TH * T6) >> 30;
        localparam logic [63:0] S1   = (S0 + (64'd1 << (30 - SINE_FRACTION_BITS - 1)))
                                       >> (30 - SINE_FRACTION_BITS);
        localparam logic [63:0] LIM  = (64'd1 << SINE_FRACTION_BITS) - 64'd1;
        localparam logic [63:0] S2   = (S1 > LIM) ? LIM : S1;
        localparam logic [63:0] SV   = QUAD[1] ? (64'd0 - S2) : S2;
        assign sine_rom[k] = SV[SIN_W-1:0];
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] r_start_angle;
    logic [ANGLE_W-1:0] r_angle_step;
    logic [RANGE_W-1:0] r_min_range;
    logic [RANGE_W-1:0] r_max_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_angle_step  <= '0;
            r_min_range   <= '0;
            r_max_range   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_ANGLE: r_start_angle <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_MIN_RANGE:   r_min_range   <= i_cfg_wdata[RANGE_W-1:0];
                CFG_MAX_RANGE:   r_max_range   <= i_cfg_wdata[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or moves on.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic s_accept;

    assign rdy3       = !r_v3 || i_m_tready;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;
    assign s_accept   = i_s_tvalid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: angle accumulator and range window check.
    // The angle register doubles as the stage-1 angle.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] n_angle;
    logic [RANGE_W-1:0] r1_range;
    logic               r1_ok;
    logic [RANGE_W-1:0] in_range;
    logic               in_special;
    logic               in_start;

    assign in_range   = i_s_tdata[RANGE_W-1:0];
    assign in_special = i_s_tuser[0];
    assign in_start   = i_s_tuser[1];
    assign n_angle    = in_start ? r_start_angle : (r_angle + r_angle_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (s_accept) begin
            r_angle <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r1_range <= in_range;
            r1_ok    <= !in_special && (in_range >= r_min_range) && (in_range <= r_max_range);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: table index for sine and cosine, registered table read.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]      cos_angle;
    logic [KMUL_W-1:0]       sin_kmul;
    logic [KMUL_W-1:0]       cos_kmul;
    logic [IDX_W-1:0]        sin_idx;
    logic [IDX_W-1:0]        cos_idx;
    logic signed [SIN_W-1:0] r2_sin;
    logic signed [SIN_W-1:0] r2_cos;
    logic [RANGE_W-1:0]      r2_range;
    logic                    r2_ok;

    assign cos_angle = r_angle + QUARTER_TURN;
    assign sin_kmul  = KMUL_W'(r_angle) * KMUL_W'(SINE_TABLE_DEPTH);
    assign cos_kmul  = KMUL_W'(cos_angle) * KMUL_W'(SINE_TABLE_DEPTH);
    assign sin_idx   = sin_kmul[KMUL_W-1:ANGLE_W];
    assign cos_idx   = cos_kmul[KMUL_W-1:ANGLE_W];

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_sin   <= sine_rom[sin_idx];
            r2_cos   <= sine_rom[cos_idx];
            r2_range <= r1_range;
            r2_ok    <= r1_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale by range and round half up to whole millimetres.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  x_prod;
    logic signed [PROD_W-1:0]  y_prod;
    logic signed [PROD_W-1:0]  x_shift;
    logic signed [PROD_W-1:0]  y_shift;
    logic signed [COORD_W-1:0] n_x;
    logic signed [COORD_W-1:0] n_y;
    logic signed [COORD_W-1:0] r3_x;
    logic signed [COORD_W-1:0] r3_y;
    logic                      r3_ok;
    logic signed [PROD_W-1:0]  round_half;

    assign round_half = PROD_W'(1) <<< (SINE_FRACTION_BITS - 1);
    assign x_prod     = $signed({1'b0, r2_range}) * r2_cos + round_half;
    assign y_prod     = $signed({1'b0, r2_range}) * r2_sin + round_half;
    assign x_shift    = x_prod >>> SINE_FRACTION_BITS;
    assign y_shift    = y_prod >>> SINE_FRACTION_BITS;
    assign n_x        = r2_ok ? x_shift[COORD_W-1:0] : '0;
    assign n_y        = r2_ok ? y_shift[COORD_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_x  <= n_x;
            r3_y  <= n_y;
            r3_ok <= r2_ok;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {6'd0, r3_y, r3_x};
    assign o_m_tuser  = r3_ok;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid set right after reset");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 40'd0))
        else $error("invalid point carries nonzero coordinates");

    a_angle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !in_start) |=> (r_angle == $past(r_angle + r_angle_step)))
        else $error("angle did not advance by the step");

    a_angle_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_start) |=> (r_angle == $past(r_start_angle)))
        else $error("angle not reloaded at scan start");

endmodule

`default_nettype wire

// File: tb/sv/polar_scan_to_cartesian_top_tb.sv
`timescale 1ns / 1ps

module polar_scan_to_cartesian_top_tb;

    import pstc_pkg::*;

    localparam int unsigned SINE_DEPTH  = 1024;
    localparam int unsigned FRAC_BITS   = 15;
    localparam int unsigned ANGLE_SHIFT = 32 - $clog2(SINE_DEPTH);
    localparam int          MAX_IDLE    = 17;
    localparam int          SETTLE      = 8;
    localparam int          CYCLE_LIMIT = 500000;

    // One converted point as it leaves the block.
    typedef struct packed {
        logic signed [COORD_W-1:0] x_mm;
        logic signed [COORD_W-1:0] y_mm;
        logic                      point_valid;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;     // [15:0] range_mm
    logic [1:0]  i_s_tuser = '0;     // [0] range_special, [1] scan_start
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;          // [16:0] x_mm, [33:17] y_mm, [39:34] zero
    logic        o_m_tuser;          // [0] point_valid
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_START_ANGLE;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    // Shadow copy of the configuration and the running scan angle.
    logic [31:0] start_angle_reg = '0;
    logic [31:0] angle_step_reg = '0;
    logic [15:0] min_range_reg = '0;
    logic [15:0] max_range_reg = 16'hFFFF;
    logic [31:0] scan_angle = '0;

    int     sine_q15 [SINE_DEPTH];
    t_point expected_points [$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     src_burst = 1'b0;
    bit     sink_burst = 1'b0;
    int     sink_hold_cycles = 0;

    polar_scan_to_cartesian_top #(
        .SINE_TABLE_DEPTH   (SINE_DEPTH),
        .SINE_FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Build the sine table: first-quadrant fold, Taylor series in Q30, rounded to Q15.
    initial begin : sine_table_init
        longint unsigned b, f, theta, th2, t, s;
        longint unsigned divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        for (int k = 0; k < SINE_DEPTH; k++) begin
            b = 64'(k);
            b = (b << 32) / SINE_DEPTH;
            f = b & 64'h3FFF_FFFF;
            if (b[30])
                f = Q30_ONE - f;
            theta = (f * HALF_PI_Q30) >> 30;
            th2 = (theta * theta) >> 30;
            t = Q30_ONE;
            for (int i = 0; i < 6; i++)
                t = Q30_ONE - ((th2 * t) >> 30) / divs[i];
            s = (theta * t) >> 30;
            s = (s + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
            if (s > (64'd1 << FRAC_BITS) - 1)
                s = (64'd1 << FRAC_BITS) - 1;
            sine_q15[k] = b[31] ? -int'(s) : int'(s);
        end
    end

    // Range times table value, rounded half toward plus infinity.
    function automatic logic signed [COORD_W-1:0] round_product(logic [15:0] r, int s);
        longint prod;
        prod = longint'(r) * longint'(s) + (longint'(1) << (FRAC_BITS - 1));
        prod = prod >>> FRAC_BITS;
        return prod[COORD_W-1:0];
    endfunction

    // Advance the scan angle and work out the point one sample turns into.
    function automatic t_point predict_point(logic [15:0] r, logic special, logic start);
        t_point p;
        logic [31:0] cos_angle;
        if (start)
            scan_angle = start_angle_reg;
        else
            scan_angle = scan_angle + angle_step_reg;
        cos_angle = scan_angle + QUARTER_TURN;
        p.point_valid = !special && r >= min_range_reg && r <= max_range_reg;
        p.x_mm = '0;
        p.y_mm = '0;
        if (p.point_valid) begin
            p.x_mm = round_product(r, sine_q15[cos_angle[31:ANGLE_SHIFT]]);
            p.y_mm = round_product(r, sine_q15[scan_angle[31:ANGLE_SHIFT]]);
        end
        return p;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Offer one sample after a random gap and log its point once the transaction completes.
    task automatic send_sample(logic [15:0] r, logic special, logic start);
        int gap;
        t_point pred;
        gap = src_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= r;
        i_s_tuser  <= {start, special};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = predict_point(r, special, start);
        expected_points.insert(expected_points.size(), pred);
    endtask

    // Stop sending and wait until every point has come out and the pipeline is empty.
    task automatic drain_points();
        i_s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_START_ANGLE: start_angle_reg = value;
            CFG_ANGLE_STEP:  angle_step_reg = value;
            CFG_MIN_RANGE:   min_range_reg = value[15:0];
            CFG_MAX_RANGE:   max_range_reg = value[15:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] start, logic [31:0] step,
                             logic [15:0] min_r, logic [15:0] max_r);
        drain_points();
        write_cfg(CFG_START_ANGLE, start);
        write_cfg(CFG_ANGLE_STEP, step);
        write_cfg(CFG_MIN_RANGE, {16'd0, min_r});
        write_cfg(CFG_MAX_RANGE, {16'd0, max_r});
    endtask

    // Without a scan start the angle accumulates from zero; range window at reset values.
    task automatic test_first_sample_after_reset();
        write_cfg(CFG_ANGLE_STEP, 32'h0100_0000);
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd1, 1'b0, 1'b0);
    endtask

    // Full range at each quarter turn, where the table saturates.
    task automatic test_quadrant_angles();
        configure(32'h0, QUARTER_TURN, 16'd0, 16'hFFFF);
        send_sample(16'hFFFF, 1'b0, 1'b1);
        repeat (4) send_sample(16'hFFFF, 1'b0, 1'b0);
    endtask

    task automatic test_step_extremes();
        configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'hFFFF);
        send_sample(16'd12345, 1'b0, 1'b1);
        send_sample(16'd40000, 1'b0, 1'b0);
        configure(32'h8000_0000, 32'h8000_0000, 16'd0, 16'hFFFF);
        send_sample(16'd777, 1'b0, 1'b1);
        send_sample(16'hFFFF, 1'b0, 1'b0);
    endtask

    // Window edges, special samples, an empty window and a single-value window.
    task automatic test_range_window();
        configure(32'h1234_5678, 32'h0123_4567, 16'd100, 16'd200);
        send_sample(16'd99, 1'b0, 1'b1);
        send_sample(16'd100, 1'b0, 1'b0);
        send_sample(16'd200, 1'b0, 1'b0);
        send_sample(16'd201, 1'b0, 1'b0);
        send_sample(16'd150, 1'b1, 1'b1);
        configure(32'h2000_0000, 32'hF000_0000, 16'd201, 16'd200);
        send_sample(16'd200, 1'b0, 1'b1);
        send_sample(16'd201, 1'b0, 1'b0);
        configure(32'h6000_0000, 32'h0000_0001, 16'd0, 16'd0);
        send_sample(16'd0, 1'b0, 1'b1);
        send_sample(16'd1, 1'b0, 1'b0);
    endtask

    // Random configurations, each followed by scans of random length and content.
    task automatic test_random_scans();
        int n;
        int scan_len;
        logic [31:0] start_a, step_a;
        logic [15:0] min_r, max_r, r;
        logic special, start;
        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 2))
                0: start_a = 32'h0;
                1: start_a = 32'hFFFF_FFFF;
                default: start_a = $urandom;
            endcase
            case ($urandom_range(0, 6))
                0: step_a = 32'h0;
                1: step_a = 32'h1;
                2: step_a = 32'h7FFF_FFFF;
                3: step_a = 32'h8000_0000;
                4: step_a = 32'hFFFF_FFFF;
                5: step_a = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
                default: step_a = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    min_r = 16'd0;
                    max_r = 16'hFFFF;
                end
                1: begin
                    min_r = 16'($urandom_range(0, 2000));
                    max_r = 16'($urandom_range(20000, 65535));
                end
                2: begin
                    max_r = 16'($urandom_range(0, 60000));
                    min_r = max_r + 16'($urandom_range(1, 5000));
                end
                3: begin
                    min_r = 16'($urandom);
                    max_r = min_r;
                end
                default: begin
                    min_r = 16'($urandom);
                    max_r = 16'($urandom);
                end
            endcase
            configure(start_a, step_a, min_r, max_r);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 100) begin
                scan_len = $urandom_range(1, 40);
                for (int i = 0; i < scan_len; i++) begin
                    start = (i == 0);
                    // Now and then a stray or missing scan start.
                    if ($urandom_range(0, 19) == 0)
                        start = 1'($urandom_range(0, 1));
                    special = ($urandom_range(0, 15) == 0);
                    case ($urandom_range(0, 9))
                        0: r = min_range_reg;
                        1: r = max_range_reg;
                        2: r = min_range_reg - 16'd1;
                        3: r = max_range_reg + 16'd1;
                        4, 5: r = 16'($urandom);
                        default: begin
                            if (min_range_reg <= max_range_reg)
                                r = 16'($urandom_range(min_range_reg, max_range_reg));
                            else
                                r = 16'($urandom);
                        end
                    endcase
                    send_sample(r, special, start);
                    n++;
                end
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        configure($urandom, $urandom, 16'd0, 16'hFFFF);
        src_burst = 1'b1;
        sink_burst = 1'b1;
        sink_hold_cycles = 300;
        send_sample(16'($urandom), 1'b0, 1'b1);
        repeat (39) send_sample(16'($urandom), 1'b0, 1'b0);
        src_burst = 1'b0;
        sink_burst = 1'b0;
    endtask

    // Point receiver: random stalls, then check each transaction against the oldest prediction.
    initial begin : point_receiver
        int stall;
        t_point want;
        logic signed [COORD_W-1:0] got_x, got_y;
        logic got_valid;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            got_x = o_m_tdata[16:0];
            got_y = o_m_tdata[33:17];
            got_valid = o_m_tuser;
            if (expected_points.size() == 0) begin
                report_error($sformatf("unexpected point x=%0d y=%0d valid=%0b",
                                       got_x, got_y, got_valid));
            end else begin
                want = expected_points.pop_front();
                if (got_x !== want.x_mm)
                    report_error($sformatf("x_mm got %0d expected %0d", got_x, want.x_mm));
                if (got_y !== want.y_mm)
                    report_error($sformatf("y_mm got %0d expected %0d", got_y, want.y_mm));
                if (got_valid !== want.point_valid)
                    report_error($sformatf("point_valid got %0b expected %0b",
                                           got_valid, want.point_valid));
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_sample_after_reset();
        test_quadrant_angles();
        test_step_extremes();
        test_range_window();
        test_random_scans();
        test_output_backpressure();
        drain_points();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
